[rtl/wspm_pkg.sv]
// ----------------------------------------------------------------------------
// wspm_pkg: shared types and constants
// Widths, register indexes and the control types of the phase mask
// weighting block and its window unit.
// ----------------------------------------------------------------------------
package wspm_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_CUTOFF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEVELS = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_WIN   = 5'b10000
	} wspm_state_t;

	typedef enum logic [3:0] {
		WS_IDLE  = 4'b0001,
		WS_CHECK = 4'b0010,
		WS_SCAN  = 4'b0100,
		WS_OUT   = 4'b1000
	} wspm_win_state_t;

	// insert request from the weighting datapath to the window unit
	typedef struct packed {
		logic start;
		logic last;
	} wspm_win_req_t;

endpackage

[rtl/wspm_stream_if.sv]
// ----------------------------------------------------------------------------
// wspm stream interfaces
// Valid/ready channels for voxel input and projected result output.
// ----------------------------------------------------------------------------
interface wspm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] magnitude;
	logic signed [15:0] high_pass_phase;
	logic        last_in_column;

	modport source (output valid, magnitude, high_pass_phase, last_in_column, input ready);
	modport sink   (input valid, magnitude, high_pass_phase, last_in_column, output ready);
endinterface

interface wspm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] projected_value;
	logic        column_end;

	modport source (output valid, projected_value, column_end, input ready);
	modport sink   (input valid, projected_value, column_end, output ready);
endinterface

[rtl/wspm_cell.sv]
// ----------------------------------------------------------------------------
// wspm_cell: one window slot
// Holds one weighted value; loads a new one or takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module wspm_cell
	import wspm_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              shift,
	input  logic [DATA_W-1:0] din,
	input  logic [DATA_W-1:0] nbr,
	output logic [DATA_W-1:0] q
);

	logic [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= din;
		end else if (shift) begin
			val_q <= nbr;
		end
	end

	assign q = val_q;

endmodule

[rtl/wspm_window.sv]
// ----------------------------------------------------------------------------
// wspm_window: forward minimum window
// Row of cells, oldest first. Scans the window for its minimum, emits it,
// then shifts the row down by one cell.
// ----------------------------------------------------------------------------
module wspm_window
	import wspm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  wspm_win_req_t     req,
	input  logic [DATA_W-1:0] val,
	input  logic [CNT_W-1:0]  win,
	output logic              idle,
	wspm_out_if.source        res
);

	wspm_win_state_t   st_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  k_q;
	logic [CNT_W-1:0]  lim_q;
	logic [DATA_W-1:0] min_q;
	logic              last_q;
	logic              cend_q;

	logic [DATA_W-1:0] cell_q [MAX_WINDOW];
	logic [IDX_W-1:0]  ins_idx;
	logic              xfer;
	logic              emit;

	// a full row drops its newest entry
	assign ins_idx = (fill_q >= CNT_W'(MAX_WINDOW)) ? IDX_W'(MAX_WINDOW - 1)
		: fill_q[IDX_W-1:0];
	assign xfer    = res.valid && res.ready;
	assign emit    = last_q ? (fill_q != '0) : (fill_q >= win);

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [DATA_W-1:0] nbr;
		if (i == MAX_WINDOW - 1) begin : g_end
			assign nbr = cell_q[i];
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end
		wspm_cell u_cell (
			.clk   (clk),
			.load  (req.start && (ins_idx == IDX_W'(i))),
			.shift (xfer),
			.din   (val),
			.nbr   (nbr),
			.q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= WS_IDLE;
			fill_q <= '0;
		end else begin
			unique case (st_q)
				WS_IDLE: begin
					if (req.start) begin
						fill_q <= CNT_W'(ins_idx) + CNT_W'(1);
						st_q   <= WS_CHECK;
					end
				end
				WS_CHECK: begin
					st_q <= emit ? WS_SCAN : WS_IDLE;
				end
				WS_SCAN: begin
					if (CNT_W'(k_q) == lim_q - CNT_W'(1)) begin
						st_q <= WS_OUT;
					end
				end
				WS_OUT: begin
					if (xfer) begin
						fill_q <= fill_q - CNT_W'(1);
						st_q   <= WS_CHECK;
					end
				end
				default: st_q <= WS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == WS_IDLE && req.start) begin
			last_q <= req.last;
		end
		if (st_q == WS_CHECK) begin
			k_q    <= '0;
			min_q  <= '1;
			lim_q  <= last_q ? fill_q : win;
			cend_q <= last_q && (fill_q == CNT_W'(1));
		end else if (st_q == WS_SCAN) begin
			if (cell_q[k_q] < min_q) begin
				min_q <= cell_q[k_q];
			end
			k_q <= k_q + IDX_W'(1);
		end
	end

	assign idle                = (st_q == WS_IDLE);
	assign res.valid           = (st_q == WS_OUT);
	assign res.projected_value = min_q;
	assign res.column_end      = cend_q;

endmodule

[rtl/swi_phase_mask_min_projection.sv]
// ----------------------------------------------------------------------------
// swi_phase_mask_min_projection: phase mask weighting with forward min window
// Weights each magnitude by a phase mask raised to a power and emits the
// minimum over a forward window of rows along a y column.
// ----------------------------------------------------------------------------
// Usage:
//   vox carries one voxel per transfer (magnitude, high-pass phase, last row
//   flag). res carries projected values, one per row, in row order; the
//   result of a column's last row has column_end set.
//   cfg_we/cfg_index/cfg_data write phase_cutoff (0), power_count (1) and
//   window_levels (2); write only while the block is idle.
// Processing (one voxel at a time, vox.ready is low while it is processed):
//   mask: set directly, or by a division by the cutoff when one is needed
//   (bit-serial restoring divider), power: power_count multiplications on one
//   17x17 multiplier, then scale, then insert and check.
//   Each emitted result adds a window scan over window_levels (or remaining
//   rows at column end) cells, an output state and a check state.
// Reset clears the state machines, the fill count, the start strobe and the
//   configuration registers; window contents stay undefined until written.
// A stalled receiver holds the result in the output register; the block
//   waits and takes no new voxel until the voxel's results are all out.
// ----------------------------------------------------------------------------
module swi_phase_mask_min_projection
	import wspm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	wspm_in_if.sink              vox,
	wspm_out_if.source           res
);

	// configuration
	logic signed [15:0] cutoff_q;
	logic [3:0]         power_q;
	logic [4:0]         levels_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 16'sh8000;
			power_q  <= 4'd4;
			levels_q <= 5'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_CUTOFF:  cutoff_q <= cfg_data;
				CFG_POWER_COUNT:   power_q  <= cfg_data[3:0];
				CFG_WINDOW_LEVELS: levels_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// zero counts as one row, anything past the row length as the full row
	logic [CNT_W-1:0] win_eff;
	always_comb begin
		if (levels_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (CNT_W'(levels_q) > CNT_W'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(levels_q);
		end
	end

	// weighting datapath
	wspm_state_t  st_q;
	logic [15:0]  mag_q;
	logic         last_q;
	logic [16:0]  rem_q;
	logic [16:0]  nc_q;
	logic [15:0]  quo_q;
	logic [3:0]   dcnt_q;
	logic [16:0]  m_q;
	logic [16:0]  w_q;
	logic [3:0]   pcnt_q;
	logic [15:0]  val_q;
	logic         win_idle;
	logic         win_idle_raw;
	wspm_win_req_t win_req;

	logic               accept;
	logic signed [16:0] p_ext;
	logic signed [16:0] c_ext;
	logic [16:0]        rem_sh;
	logic               qbit;
	logic [15:0]        quo_nx;
	logic [33:0]        prod_w;
	logic [32:0]        prod_v;

	assign vox.ready = (st_q == ST_IDLE);
	assign accept    = vox.valid && vox.ready;
	assign p_ext     = 17'(vox.high_pass_phase);
	assign c_ext     = 17'(cutoff_q);

	// one restoring division step; remainder stays below the divisor
	assign rem_sh = {rem_q[15:0], 1'b0};
	assign qbit   = (rem_sh >= nc_q);
	assign quo_nx = {quo_q[14:0], qbit};

	assign prod_w = w_q * m_q;
	assign prod_v = w_q * {1'b0, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= (p_ext > 0 || p_ext <= c_ext) ? ST_MUL : ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (pcnt_q == '0) begin
						st_q <= ST_SCALE;
					end
				end
				ST_SCALE: st_q <= ST_WIN;
				ST_WIN: begin
					if (win_idle) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q  <= vox.magnitude;
					last_q <= vox.last_in_column;
					w_q    <= ONE_Q16;
					pcnt_q <= power_q;
					rem_q  <= 17'(-p_ext);
					nc_q   <= 17'(-c_ext);
					quo_q  <= '0;
					dcnt_q <= 4'd15;
					if (p_ext > 0) begin
						m_q <= ONE_Q16;
					end else begin
						m_q <= '0;
					end
				end
			end
			ST_DIV: begin
				rem_q  <= qbit ? (rem_sh - nc_q) : rem_sh;
				quo_q  <= quo_nx;
				dcnt_q <= dcnt_q - 4'd1;
				if (dcnt_q == '0) begin
					m_q <= ONE_Q16 - {1'b0, quo_nx};
				end
			end
			ST_MUL: begin
				if (pcnt_q != '0) begin
					w_q    <= prod_w[32:16];
					pcnt_q <= pcnt_q - 4'd1;
				end
			end
			ST_SCALE: val_q <= prod_v[31:16];
			ST_WIN: ;
			default: ;
		endcase
	end

	// the window unit latches the value on the cycle after scaling
	logic start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= (st_q == ST_SCALE);
		end
	end

	assign win_req.start = start_q;
	assign win_req.last  = last_q;

	wspm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (win_req),
		.val    (val_q),
		.win    (win_eff),
		.idle   (win_idle_raw),
		.res    (res)
	);

	// ST_WIN must not see the idle window before the insert lands
	assign win_idle = win_idle_raw && !start_q && (st_q != ST_SCALE);

endmodule

[tb/sv/swi_phase_mask_min_projection_tb.sv]
// ----------------------------------------------------------------------------
// swi_phase_mask_min_projection_tb: self-checking bench for the SWI block
// Drives voxel columns through the stream interfaces under random idling,
// predicts each projected value from an internal weighting and window model,
// and compares every result transfer in order.
// ----------------------------------------------------------------------------
module swi_phase_mask_min_projection_tb;
	import wspm_pkg::*;

	typedef struct {
		logic [15:0] magnitude;
		logic signed [15:0] high_pass_phase;
		logic        last_in_column;
	} voxel_t;

	typedef struct {
		logic [15:0] projected_value;
		logic        column_end;
	} projection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	wspm_in_if  vox ();
	wspm_out_if res ();

	swi_phase_mask_min_projection DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .vox(vox.sink), .res(res.source)
	);

	always #4 clk = ~clk;

	// bench copy of the registers and the row window
	logic signed [15:0] cutoff_q;
	logic [3:0]         power_q;
	logic [4:0]         levels_q;
	logic [15:0]        rows [MAX_WINDOW];
	int                 rows_held;

	voxel_t      voxel_queue [$];
	projection_t projection_queue [$];
	int          mismatches = 0;
	bit          no_idle = 1'b0; // long stretch with both sides always active

	// mask in Q1.16, then the truncating power chain and the magnitude scale
	function automatic logic [15:0] masked_magnitude(logic [15:0] mag,
			logic signed [15:0] ph);
		logic [16:0] mask;
		logic [63:0] w;
		logic [31:0] ratio;
		if (ph > 0)
			mask = 17'h10000;
		else if (ph <= cutoff_q)
			mask = 17'h0;
		else begin
			ratio = (32'(-32'(ph)) << 16) / 32'(-32'(cutoff_q));
			mask = 17'(32'h10000 - ratio);
		end
		w = 64'h10000;
		for (int i = 0; i < power_q; i++)
			w = (w * mask) >> 16;
		return 16'((w * mag) >> 16);
	endfunction

	function automatic logic [15:0] row_min(int first, int stop);
		logic [15:0] m;
		m = 16'hFFFF;
		for (int i = first; i < stop && i < MAX_WINDOW; i++)
			if (rows[i] < m) m = rows[i];
		return m;
	endfunction

	function automatic void project_voxel(voxel_t v);
		int win;
		projection_t p;
		win = (levels_q == 0) ? 1 : (levels_q > MAX_WINDOW) ? MAX_WINDOW : levels_q;
		if (rows_held >= MAX_WINDOW) rows_held = MAX_WINDOW - 1;
		rows[rows_held] = masked_magnitude(v.magnitude, v.high_pass_phase);
		rows_held++;
		if (v.last_in_column) begin
			// column end: flush every pending row against the rest of the column
			for (int i = 0; i < rows_held; i++) begin
				p.projected_value = row_min(i, rows_held);
				p.column_end = (i + 1 == rows_held);
				projection_queue = {projection_queue, p};
			end
			rows_held = 0;
		end else begin
			// also covers a window shrunk below the rows already held
			while (rows_held >= win) begin
				p.projected_value = row_min(0, win);
				p.column_end = 1'b0;
				projection_queue = {projection_queue, p};
				for (int i = 0; i < MAX_WINDOW - 1; i++) rows[i] = rows[i + 1];
				rows_held--;
			end
		end
	endfunction

	// driver: each transfer pops the queue head; prediction at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vox.valid <= 1'b0;
			vox.magnitude <= '0;
			vox.high_pass_phase <= '0;
			vox.last_in_column <= 1'b0;
		end else begin
			if (vox.valid && vox.ready) begin
				project_voxel(voxel_queue.pop_front());
			end
			if ((!vox.valid || vox.ready)) begin
				if (voxel_queue.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
					vox.valid <= 1'b1;
					vox.magnitude <= voxel_queue[0].magnitude;
					vox.high_pass_phase <= voxel_queue[0].high_pass_phase;
					vox.last_in_column <= voxel_queue[0].last_in_column;
				end else
					vox.valid <= 1'b0;
			end
		end
	end

	// monitor: random backpressure, in-order compare of each result transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= no_idle || ($urandom_range(99) >= 27);
			if (res.valid && res.ready) begin
				if (projection_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %0d end %0b",
							res.projected_value, res.column_end);
				end else begin
					projection_t e;
					e = projection_queue.pop_front();
					if (e.projected_value !== res.projected_value ||
							e.column_end !== res.column_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0b got %0d/%0b",
								e.projected_value, e.column_end,
								res.projected_value, res.column_end);
					end
				end
			end
		end
	end

	task automatic add_voxel(logic [15:0] mag, logic signed [15:0] ph, logic last);
		voxel_t v;
		v.magnitude = mag;
		v.high_pass_phase = ph;
		v.last_in_column = last;
		voxel_queue = {voxel_queue, v};
	endtask

	// quiet point: all voxels taken, all results out, then a settle pause
	task automatic drain();
		while (voxel_queue.size() > 0 || vox.valid || projection_queue.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PHASE_CUTOFF:  cutoff_q = val;
			CFG_POWER_COUNT:   power_q = val[3:0];
			CFG_WINDOW_LEVELS: levels_q = val[4:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] cut, logic [3:0] pw, logic [4:0] lv);
		write_reg(CFG_PHASE_CUTOFF, cut);
		write_reg(CFG_POWER_COUNT, {12'h0, pw});
		write_reg(CFG_WINDOW_LEVELS, {11'h0, lv});
	endtask

	// random phase biased toward the mask ramp between cutoff and zero
	function automatic logic [15:0] pick_phase();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(32767));
			default: return 16'(-32'($urandom_range(32'(-32'(cutoff_q)))));
		endcase
	endfunction

	task automatic random_columns(int count);
		int rows_left;
		while (count > 0) begin
			rows_left = $urandom_range(24, 1);
			if ($urandom_range(9) == 0) rows_left = $urandom_range(3, 1);
			for (int r = 0; r < rows_left && count > 0; r++, count--)
				add_voxel(($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom),
					pick_phase(), (r == rows_left - 1) || count == 1);
		end
	endtask

	initial begin
		cutoff_q = -16'sd32768;
		power_q = 4'd4;
		levels_q = 5'd4;
		rows_held = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed at reset values: field extremes, phase around zero and cutoff
		add_voxel(16'hFFFF, 16'sh7FFF, 1'b0);
		add_voxel(16'h0000, 16'sh8000, 1'b0);
		add_voxel(16'hFFFF, 16'sh0000, 1'b0);
		add_voxel(16'hFFFF, 16'sh0001, 1'b0);
		add_voxel(16'hFFFF, 16'shFFFF, 1'b0);
		add_voxel(16'hAAAA, 16'shC000, 1'b0);
		add_voxel(16'h5555, 16'sh8001, 1'b1);
		add_voxel(16'h1234, 16'sh0100, 1'b1); // one-row column
		drain();

		// cutoff of -1, no power, window of one
		configure(16'hFFFF, 4'd0, 5'd1);
		add_voxel(16'hFFFF, 16'shFFFF, 1'b0);
		add_voxel(16'hFFFF, 16'sh0000, 1'b0);
		add_voxel(16'hFFFF, 16'shFFFE, 1'b1);
		drain();

		// window zero acts as one; full power
		configure(16'hF000, 4'd15, 5'd0);
		add_voxel(16'hFFFF, 16'shF800, 1'b0);
		add_voxel(16'h8000, 16'sh0010, 1'b1);
		drain();

		// oversize window is clamped; a column runs longer than the store
		configure(16'h8000, 4'd2, 5'd31);
		for (int i = 0; i < 20; i++)
			add_voxel(16'($urandom), pick_phase(), i == 19);
		drain();

		// window of 16 then shrunk to 2 mid-column
		configure(16'hC000, 4'd3, 5'd16);
		for (int i = 0; i < 10; i++)
			add_voxel(16'($urandom), pick_phase(), 1'b0);
		drain();
		write_reg(CFG_WINDOW_LEVELS, 16'd2);
		add_voxel(16'h4000, 16'shE000, 1'b0);
		add_voxel(16'h4000, 16'sh2000, 1'b1);
		drain();

		// random phases across several settings, extremes included
		configure(16'h8000, 4'd4, 5'd4);
		random_columns(60);
		drain();
		configure(16'hFFFF, 4'd15, 5'd16);
		random_columns(40);
		drain();
		no_idle = 1'b1;
		configure(16'($urandom_range(32767, 1) * -1), 4'($urandom), 5'($urandom_range(16, 1)));
		random_columns(60);
		drain();
		no_idle = 1'b0;
		configure(16'hE000, 4'd1, 5'd3);
		random_columns(80);
		drain();
		configure(16'($urandom_range(32768, 1) * -1), 4'($urandom), 5'($urandom));
		random_columns(45);
		drain();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
